/* rtl/core/swtd_pkg.sv */
package swtd_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // Register widths.
    localparam int THR_W = 14;
    localparam int WS_W  = 9;
    localparam int MC_W  = 9;
    localparam int CL_W  = 17;

    // Position fields and the reported count.
    localparam int POS_W     = 16;
    localparam int CNT_OUT_W = 9;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_COUNT    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LENGTH = CFG_INDEX_W'(3);

    // Register reset values.
    localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(50);
    localparam logic [WS_W-1:0]  WINDOW_SIZE_RST  = WS_W'(256);
    localparam logic [MC_W-1:0]  MIN_COUNT_RST    = MC_W'(128);
    localparam logic [CL_W-1:0]  CHUNK_LENGTH_RST = CL_W'(1024);

    // Largest chunk length that the oldest position can span.
    localparam logic [CL_W-1:0] CHUNK_MAX = CL_W'(65536);

    // Broadcast control for the row of window cells.
    typedef struct packed {
        logic clear;
        logic load;
        logic full;
        logic flag;
    } cell_ctrl_t;

endpackage

/* rtl/core/swtd_if.sv */
interface swtd_in_if #(
    parameter int SAMPLE_BITS = swtd_pkg::SAMPLE_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     sample;
    logic [swtd_pkg::POS_W-1:0]        sample_index;
    logic [swtd_pkg::POS_W-1:0]        chunk_index;

    modport source (output valid, output sample, output sample_index, output chunk_index,
                    input ready);
    modport sink   (input valid, input sample, input sample_index, input chunk_index,
                    output ready);
endinterface

interface swtd_out_if;
    logic                              valid;
    logic                              ready;
    logic [swtd_pkg::CNT_OUT_W-1:0]    flag_count;
    logic [swtd_pkg::POS_W-1:0]        oldest_sample;
    logic [swtd_pkg::POS_W-1:0]        oldest_chunk;
    logic [swtd_pkg::POS_W-1:0]        newest_sample;
    logic [swtd_pkg::POS_W-1:0]        newest_chunk;

    modport source (output valid, output flag_count, output oldest_sample,
                    output oldest_chunk, output newest_sample, output newest_chunk,
                    input ready);
    modport sink   (input valid, input flag_count, input oldest_sample,
                    input oldest_chunk, input newest_sample, input newest_chunk,
                    output ready);
endinterface

/* rtl/core/swtd_flag.sv */
module swtd_flag #(
    parameter int SAMPLE_BITS = swtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [swtd_pkg::THR_W-1:0]     threshold,
    output logic                           flag
);
    localparam int CMP_W = SAMPLE_BITS + swtd_pkg::THR_W;

    logic [SAMPLE_BITS-1:0] mag;
    logic [CMP_W-1:0]       scaled;
    logic [CMP_W-1:0]       limit;

    // The most negative code negates to itself, which read unsigned is full scale.
    assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    // Times 100 as 64 + 32 + 4.
    assign scaled = (CMP_W'(mag) << 6) + (CMP_W'(mag) << 5) + (CMP_W'(mag) << 2);
    assign limit  = CMP_W'(threshold) << (SAMPLE_BITS - 1);
    assign flag   = scaled > limit;
endmodule

/* rtl/core/swtd_cell.sv */
module swtd_cell #(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swtd_pkg::cell_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]      insert_pos,
    input  logic                  upper,
    output logic                  flag_q
);
    logic flag_reg;
    logic flag_next;
    logic hit;

    assign hit = insert_pos == IDX_W'(CELL_IDX);

    // A full window moves every flag one cell toward the oldest end.
    always_comb
    begin
        priority if (ctrl.clear)
        begin
            flag_next = 1'b0;
        end
        else if (ctrl.load && ctrl.full)
        begin
            flag_next = hit ? ctrl.flag : upper;
        end
        else if (ctrl.load && hit)
        begin
            flag_next = ctrl.flag;
        end
        else
        begin
            flag_next = flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign flag_q = flag_reg;
endmodule

/* rtl/core/sliding_window_threshold_detector.sv */
// A report is registered from the sample that causes it and shown in the cycle after it.
// The block takes one sample per cycle; the output register takes a new report while the
// previous one is being taken, and stalls the input only when it holds an untaken report.
// The flag cells, fill, count and oldest position all update in the accepting cycle.
// Reset (asynchronous, active low) empties the window and restores register defaults.
module sliding_window_threshold_detector #(
    parameter int MAX_WINDOW  = swtd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swtd_pkg::CFG_DATA_W-1:0]     cfg_data,
    swtd_in_if.sink                             samples,
    swtd_out_if.source                          reports
);
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int CMPW  = (CW > swtd_pkg::MC_W) ? CW : swtd_pkg::MC_W;
    localparam int POS_W = swtd_pkg::POS_W;
    localparam int CL_W  = swtd_pkg::CL_W;

    logic [swtd_pkg::THR_W-1:0] thr_reg;
    logic [swtd_pkg::WS_W-1:0]  ws_reg;
    logic [swtd_pkg::MC_W-1:0]  mc_reg;
    logic [CL_W-1:0]            cl_reg;

    logic [CW-1:0]    fill_reg,   fill_next;
    logic [CW-1:0]    total_reg,  total_next;
    logic [POS_W-1:0] opos_reg,   opos_next;
    logic [POS_W-1:0] ochunk_reg, ochunk_next;

    logic                         out_valid_reg;
    logic [swtd_pkg::CNT_OUT_W-1:0] cnt_out_reg;
    logic [POS_W-1:0]             osamp_out_reg, ochunk_out_reg, nsamp_out_reg, nchunk_out_reg;

    logic                 accept;
    logic                 flag;
    logic                 full;
    logic                 report;
    logic                 ws_write;
    logic [CW-1:0]        eff_size;
    logic [CL_W-1:0]      eff_chunk;
    logic [CL_W-1:0]      pos_inc;
    logic [IDX_W-1:0]     insert_pos;
    logic [MAX_WINDOW-1:0] cell_q;
    swtd_pkg::cell_ctrl_t ctrl;

    assign samples.ready = !out_valid_reg || reports.ready;
    assign accept        = samples.valid && samples.ready;
    assign ws_write      = cfg_we && (cfg_index == swtd_pkg::REG_WINDOW_SIZE);

    swtd_flag #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_flag (
        .sample    (samples.sample),
        .threshold (thr_reg),
        .flag      (flag)
    );

    always_comb
    begin
        priority if (ws_reg == '0)
        begin
            eff_size = CW'(1);
        end
        else if (32'(ws_reg) > MAX_WINDOW)
        begin
            eff_size = CW'(MAX_WINDOW);
        end
        else
        begin
            eff_size = CW'(ws_reg);
        end
    end

    always_comb
    begin
        priority if (cl_reg == '0)
        begin
            eff_chunk = CL_W'(1);
        end
        else if (cl_reg > swtd_pkg::CHUNK_MAX)
        begin
            eff_chunk = swtd_pkg::CHUNK_MAX;
        end
        else
        begin
            eff_chunk = cl_reg;
        end
    end

    assign full       = fill_reg >= eff_size;
    // The newest flag lands at the top of the window when full, else just past the fill.
    assign insert_pos = full ? IDX_W'(eff_size - 1'b1) : IDX_W'(fill_reg);

    assign ctrl.clear = ws_write;
    assign ctrl.load  = accept;
    assign ctrl.full  = full;
    assign ctrl.flag  = flag;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic upper;
        if (i == MAX_WINDOW - 1)
        begin : g_top
            assign upper = 1'b0;
        end
        else
        begin : g_mid
            assign upper = cell_q[i+1];
        end

        swtd_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .insert_pos (insert_pos),
            .upper      (upper),
            .flag_q     (cell_q[i])
        );
    end

    assign pos_inc = CL_W'(opos_reg) + 1'b1;

    always_comb
    begin
        fill_next   = fill_reg;
        total_next  = total_reg;
        opos_next   = opos_reg;
        ochunk_next = ochunk_reg;
        if (accept)
        begin
            if (fill_reg == '0)
            begin
                opos_next   = samples.sample_index;
                ochunk_next = samples.chunk_index;
            end
            if (full)
            begin
                // The oldest flag sits in the first cell and leaves the window here.
                total_next = total_reg - CW'(cell_q[0]) + CW'(flag);
                if (pos_inc >= eff_chunk)
                begin
                    opos_next   = '0;
                    ochunk_next = ochunk_reg + 1'b1;
                end
                else
                begin
                    opos_next = POS_W'(pos_inc);
                end
            end
            else
            begin
                fill_next  = fill_reg + 1'b1;
                total_next = total_reg + CW'(flag);
            end
        end
    end

    assign report = CMPW'(total_next) >= CMPW'(mc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= swtd_pkg::THRESHOLD_RST;
            ws_reg        <= swtd_pkg::WINDOW_SIZE_RST;
            mc_reg        <= swtd_pkg::MIN_COUNT_RST;
            cl_reg        <= swtd_pkg::CHUNK_LENGTH_RST;
            fill_reg      <= '0;
            total_reg     <= '0;
            opos_reg      <= '0;
            ochunk_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            opos_reg   <= opos_next;
            ochunk_reg <= ochunk_next;
            if (ws_write)
            begin
                fill_reg  <= '0;
                total_reg <= '0;
            end
            else
            begin
                fill_reg  <= fill_next;
                total_reg <= total_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    swtd_pkg::REG_THRESHOLD:    thr_reg <= swtd_pkg::THR_W'(cfg_data);
                    swtd_pkg::REG_WINDOW_SIZE:  ws_reg  <= swtd_pkg::WS_W'(cfg_data);
                    swtd_pkg::REG_MIN_COUNT:    mc_reg  <= swtd_pkg::MC_W'(cfg_data);
                    swtd_pkg::REG_CHUNK_LENGTH: cl_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
            if (accept)
            begin
                out_valid_reg <= report;
            end
            else if (reports.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && report)
        begin
            cnt_out_reg    <= swtd_pkg::CNT_OUT_W'(total_next);
            osamp_out_reg  <= opos_next;
            ochunk_out_reg <= ochunk_next;
            nsamp_out_reg  <= samples.sample_index;
            nchunk_out_reg <= samples.chunk_index;
        end
    end

    assign reports.valid         = out_valid_reg;
    assign reports.flag_count    = cnt_out_reg;
    assign reports.oldest_sample = osamp_out_reg;
    assign reports.oldest_chunk  = ochunk_out_reg;
    assign reports.newest_sample = nsamp_out_reg;
    assign reports.newest_chunk  = nchunk_out_reg;
endmodule

/* rtl/core/swtd_checker.sv */
module swtd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [swtd_pkg::POS_W-1:0]         in_sample_index,
    input  logic [swtd_pkg::POS_W-1:0]         in_chunk_index,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [swtd_pkg::POS_W-1:0]         out_newest_sample,
    input  logic [swtd_pkg::POS_W-1:0]         out_newest_chunk
);
    // A stalled report stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("report dropped while stalled");

    // The input is only held off by an untaken report.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

    // A report only appears right after a sample transaction.
    a_report_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("report without a sample transaction");

    // A report following a sample transaction carries that sample's position.
    a_newest_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid
            || (out_newest_sample == $past(in_sample_index)
                && out_newest_chunk == $past(in_chunk_index)))
        else $error("newest position does not match the sample taken");
endmodule

bind sliding_window_threshold_detector swtd_checker u_swtd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (samples.valid),
    .in_ready          (samples.ready),
    .in_sample_index   (samples.sample_index),
    .in_chunk_index    (samples.chunk_index),
    .out_valid         (reports.valid),
    .out_ready         (reports.ready),
    .out_newest_sample (reports.newest_sample),
    .out_newest_chunk  (reports.newest_chunk)
);
